>>> rtl/kfr_pkg.sv
// shared types, constants and reply table for the k-line frame responder
`timescale 1ns / 1ps
package kfr_pkg;

  // default configuration
  localparam int LONG_RAMP_LEN_DEF  = 32;
  localparam int SHORT_RAMP_LEN_DEF = 16;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // request side
  localparam logic [7:0] SYNC_BYTE     = 8'h81;
  localparam int         MIN_FRAME_LEN = 4;
  localparam logic [7:0] LONG_ID       = 8'h24;
  localparam logic [7:0] SHORT_ID      = 8'h9D;

  // reply side
  localparam logic [7:0] LIVE_HDR     = 8'h84;
  localparam logic [7:0] FMT_BIT      = 8'h80;
  localparam logic [7:0] LEN_MASK     = 8'h3F;
  localparam logic [7:0] TESTER_ADDR  = 8'hF1;
  localparam logic [7:0] ECU_ADDR     = 8'h11;
  localparam logic [7:0] SID_OFFSET   = 8'h40;
  localparam int         HEAD_BYTES   = 5;
  localparam int         FIXED_LEN    = 8;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_LONG,
    KIND_SHORT,
    KIND_LIVE
  } reply_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

  // one queued reply job
  typedef struct packed {
    reply_kind_t kind;
    logic [7:0]  service;
    logic [7:0]  local_id;
    logic [7:0]  live_low;
    logic [7:0]  live_high;
  } cmd_t;

  // fixed start-communication reply
  function automatic logic [7:0] start_reply(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h83;
      3'd1: b = 8'h83;
      3'd2: b = 8'hF1;
      3'd3: b = 8'h10;
      3'd4: b = 8'hC1;
      3'd5: b = 8'hDF;
      3'd6: b = 8'h8F;
      3'd7: b = 8'hB3;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/kfr_front.sv
// receive side: sync search, frame parsing, checksum check and reply selection
`timescale 1ns / 1ps
module kfr_front
  import kfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic [7:0] live_data_low,
  input  logic [7:0] live_data_high,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_wdata
);

  logic       sync_seen, sync_seen_next;
  logic       in_frame, in_frame_next;
  logic [6:0] byte_index, byte_index_next;
  logic [6:0] frame_total, frame_total_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] service_byte, service_byte_next;
  logic [7:0] local_id_byte, local_id_byte_next;
  logic       session_open, session_open_next;

  logic       accept;
  logic [7:0] svc_cap;
  logic [7:0] lid_cap;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    sync_seen_next     = sync_seen;
    in_frame_next      = in_frame;
    byte_index_next    = byte_index;
    frame_total_next   = frame_total;
    running_sum_next   = running_sum;
    service_byte_next  = service_byte;
    local_id_byte_next = local_id_byte;
    session_open_next  = session_open;
    q_push             = 1'b0;
    svc_cap            = (byte_index == 7'd3) ? rx_byte : service_byte;
    lid_cap            = (byte_index == 7'd4) ? rx_byte : local_id_byte;
    q_wdata.kind       = KIND_LIVE;
    q_wdata.service    = svc_cap;
    q_wdata.local_id   = lid_cap;
    q_wdata.live_low   = live_data_low;
    q_wdata.live_high  = live_data_high;

    if (!session_open) begin
      q_wdata.kind = KIND_START;
    end else if (lid_cap == LONG_ID) begin
      q_wdata.kind = KIND_LONG;
    end else if (lid_cap == SHORT_ID) begin
      q_wdata.kind = KIND_SHORT;
    end

    if (accept && (sync_seen || rx_byte == SYNC_BYTE)) begin
      sync_seen_next = 1'b1;
      if (!in_frame) begin
        // header with top bit set opens a frame
        if (rx_byte[7]) begin
          frame_total_next   = {1'b0, rx_byte[5:0]} + 7'(MIN_FRAME_LEN);
          running_sum_next   = rx_byte;
          byte_index_next    = 7'd1;
          in_frame_next      = 1'b1;
          service_byte_next  = 8'h00;
          local_id_byte_next = 8'h00;
        end
      end else if (byte_index + 7'd1 != frame_total) begin
        service_byte_next  = svc_cap;
        local_id_byte_next = lid_cap;
        running_sum_next   = running_sum + rx_byte;
        byte_index_next    = byte_index + 7'd1;
      end else begin
        // checksum byte
        in_frame_next      = 1'b0;
        byte_index_next    = 7'd0;
        running_sum_next   = 8'h00;
        service_byte_next  = 8'h00;
        local_id_byte_next = 8'h00;
        if (running_sum == rx_byte) begin
          q_push            = 1'b1;
          session_open_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_seen     <= 1'b0;
      in_frame      <= 1'b0;
      byte_index    <= 7'd0;
      frame_total   <= 7'd0;
      running_sum   <= 8'h00;
      service_byte  <= 8'h00;
      local_id_byte <= 8'h00;
      session_open  <= 1'b0;
    end else begin
      sync_seen     <= sync_seen_next;
      in_frame      <= in_frame_next;
      byte_index    <= byte_index_next;
      frame_total   <= frame_total_next;
      running_sum   <= running_sum_next;
      service_byte  <= service_byte_next;
      local_id_byte <= local_id_byte_next;
      session_open  <= session_open_next;
    end
  end

endmodule

>>> rtl/kfr_queue.sv
// short job queue between the receive and transmit sides
`timescale 1ns / 1ps
module kfr_queue
  import kfr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

>>> rtl/kfr_back.sv
// transmit side: reply byte sequencer with output register
`timescale 1ns / 1ps
module kfr_back
  import kfr_pkg::*;
#(
  parameter int LONG_RAMP_LEN  = LONG_RAMP_LEN_DEF,
  parameter int SHORT_RAMP_LEN = SHORT_RAMP_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_rdata,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last_byte
);

  localparam int MAX_RAMP = (LONG_RAMP_LEN > SHORT_RAMP_LEN) ? LONG_RAMP_LEN : SHORT_RAMP_LEN;
  localparam int MAX_LEN  = MAX_RAMP + HEAD_BYTES + 1;
  localparam int POS_W    = $clog2(MAX_LEN);
  localparam logic [7:0] LONG_HDR  = FMT_BIT | (8'(LONG_RAMP_LEN + 2) & LEN_MASK);
  localparam logic [7:0] SHORT_HDR = FMT_BIT | (8'(SHORT_RAMP_LEN + 2) & LEN_MASK);

  back_state_t      state, state_next;
  cmd_t             cmd, cmd_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       tx_sum, tx_sum_next;
  logic             out_vld, out_vld_next;
  logic [7:0]       out_byte, out_byte_next;
  logic             out_last, out_last_next;

  logic [POS_W-1:0] last_pos;
  logic             is_last;
  logic [7:0]       byte_val;

  assign out_valid = out_vld;
  assign tx_byte   = out_byte;
  assign last_byte = out_last;

  always_comb begin
    case (cmd.kind)
      KIND_LONG:  last_pos = POS_W'(LONG_RAMP_LEN + HEAD_BYTES);
      KIND_SHORT: last_pos = POS_W'(SHORT_RAMP_LEN + HEAD_BYTES);
      default:    last_pos = POS_W'(FIXED_LEN - 1);
    endcase
    is_last = (pos == last_pos);

    if (cmd.kind == KIND_START) begin
      byte_val = start_reply(pos[2:0]);
    end else if (is_last) begin
      byte_val = tx_sum;
    end else if (pos == POS_W'(0)) begin
      byte_val = (cmd.kind == KIND_LONG)  ? LONG_HDR :
                 (cmd.kind == KIND_SHORT) ? SHORT_HDR : LIVE_HDR;
    end else if (pos == POS_W'(1)) begin
      byte_val = TESTER_ADDR;
    end else if (pos == POS_W'(2)) begin
      byte_val = ECU_ADDR;
    end else if (pos == POS_W'(3)) begin
      byte_val = cmd.service + SID_OFFSET;
    end else if (pos == POS_W'(4)) begin
      byte_val = cmd.local_id;
    end else if (cmd.kind == KIND_LIVE) begin
      byte_val = (pos == POS_W'(HEAD_BYTES)) ? cmd.live_high : cmd.live_low;
    end else begin
      // ramp: live_high plus offset within the ramp
      byte_val = cmd.live_high + (8'(pos) - 8'(HEAD_BYTES));
    end
  end

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    pos_next      = pos;
    tx_sum_next   = tx_sum;
    out_vld_next  = out_vld && out_stall;
    out_byte_next = out_byte;
    out_last_next = out_last;
    q_pop         = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_next    = q_rdata;
          pos_next    = '0;
          tx_sum_next = 8'h00;
          state_next  = BK_SEND;
        end
      end
      BK_SEND: begin
        if (!out_vld || !out_stall) begin
          out_vld_next  = 1'b1;
          out_byte_next = byte_val;
          out_last_next = is_last;
          tx_sum_next   = tx_sum + byte_val;
          pos_next      = pos + POS_W'(1);
          if (is_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    pos      <= pos_next;
    tx_sum   <= tx_sum_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

endmodule

>>> rtl/kline_frame_responder.sv
// top level of the k-line frame responder: receive parser, job queue, reply sequencer
`timescale 1ns / 1ps
// a good checksum beat pushes a job; the sequencer pops it, then registers the reply beats
// throughput: one request beat per cycle unless in_stall; one reply beat per cycle unless
// out_stall (8 to ramp+6 beats per reply); the receive side stalls only while the job queue
// (QUEUE_DEPTH jobs) is full; the transmit side runs one reply at a time, idle between replies
// reset (rst, synchronous, active high) clears sync, frame, session, queue and output valid
module kline_frame_responder
  import kfr_pkg::*;
#(
  parameter int LONG_RAMP_LEN  = LONG_RAMP_LEN_DEF,
  parameter int SHORT_RAMP_LEN = SHORT_RAMP_LEN_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic [7:0] live_data_low,
  input  logic [7:0] live_data_high,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last_byte
);

  // queue handshake between the two sides
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  // front: finds the sync byte, walks each frame, checks its sum and picks the reply
  kfr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .live_data_low  (live_data_low),
    .live_data_high (live_data_high),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // queue: holds reply jobs so parsing continues while a reply is still going out
  kfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: emits the reply beats; all replies but the fixed start reply close with a computed checksum
  kfr_back #(
    .LONG_RAMP_LEN  (LONG_RAMP_LEN),
    .SHORT_RAMP_LEN (SHORT_RAMP_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last_byte (last_byte)
  );

  // no job is written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // no job is taken from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // the start reply is chosen for one job only: it is never followed by another start
  a_single_start: assert property (@(posedge clk) disable iff (rst)
    q_push && q_wdata.kind == KIND_START |=> !(q_push && q_wdata.kind == KIND_START))
    else $error("start reply queued twice in a row");

endmodule

>>> tb/kline_frame_responder_test.sv
// self-checking testbench for the k-line frame responder
`timescale 1ns / 1ps
module kline_frame_responder_test
  import kfr_pkg::*;
();

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 210;
  localparam int TAIL_CYCLES    = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  // tracks request parsing and holds the reply beats still owed by the block
  class kline_reply_scoreboard;
    bit          synced;
    bit          framing;
    logic [6:0]  pos;
    logic [6:0]  frame_len;
    logic [7:0]  req_sum;
    logic [7:0]  svc;
    logic [7:0]  lid;
    bit          session;
    logic [7:0]  reply_sum;
    reply_beat_t owed_q[$];
    int          mismatches;

    function new();
      synced     = 0;
      framing    = 0;
      pos        = '0;
      frame_len  = '0;
      req_sum    = '0;
      svc        = '0;
      lid        = '0;
      session    = 0;
      reply_sum  = '0;
      mismatches = 0;
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch: %s got %02h want %02h", what, got, want);
      mismatches++;
    endtask

    function void emit(logic [7:0] data);
      owed_q.push_back('{data: data, last: 1'b0});
      reply_sum = reply_sum + data;
    endfunction

    function void emit_sum();
      owed_q.push_back('{data: reply_sum, last: 1'b1});
    endfunction

    function void emit_head(logic [7:0] hdr);
      reply_sum = '0;
      emit(hdr);
      emit(TESTER_ADDR);
      emit(ECU_ADDR);
      emit(svc + SID_OFFSET);
      emit(lid);
    endfunction

    function void emit_ramp(logic [7:0] hdr, int len, logic [7:0] base);
      emit_head(hdr);
      for (int i = 0; i < len; i++) emit(base + 8'(i));
      emit_sum();
    endfunction

    function void emit_start();
      logic [7:0] fixed [0:7];
      fixed = '{8'h83, 8'h83, 8'hF1, 8'h10, 8'hC1, 8'hDF, 8'h8F, 8'hB3};
      for (int i = 0; i < 8; i++)
        owed_q.push_back('{data: fixed[i], last: (i == 7)});
    endfunction

    // one accepted request beat
    function void note_rx(logic [7:0] rx, logic [7:0] lo, logic [7:0] hi);
      bit good;
      if (!synced && rx == SYNC_BYTE) synced = 1;
      if (!synced) return;
      if (!framing) begin
        if (rx[7]) begin
          frame_len = 7'(rx[5:0]) + 7'(MIN_FRAME_LEN);
          req_sum   = rx;
          pos       = 7'd1;
          framing   = 1;
          svc       = '0;
          lid       = '0;
        end
        return;
      end
      if (pos == 7'd3) svc = rx;
      else if (pos == 7'd4) lid = rx;
      if (pos + 7'd1 != frame_len) begin
        req_sum = req_sum + rx;
        pos     = pos + 7'd1;
        return;
      end
      good    = (req_sum == rx);
      framing = 0;
      pos     = '0;
      req_sum = '0;
      if (good) begin
        if (!session) begin
          session = 1;
          emit_start();
        end else if (lid == LONG_ID) begin
          emit_ramp(FMT_BIT | (8'(LONG_RAMP_LEN_DEF + 2) & LEN_MASK), LONG_RAMP_LEN_DEF, hi);
        end else if (lid == SHORT_ID) begin
          emit_ramp(FMT_BIT | (8'(SHORT_RAMP_LEN_DEF + 2) & LEN_MASK), SHORT_RAMP_LEN_DEF, hi);
        end else begin
          emit_head(LIVE_HDR);
          emit(hi);
          emit(lo);
          emit_sum();
        end
      end
      svc = '0;
      lid = '0;
    endfunction

    // one accepted reply beat
    task check_tx(logic [7:0] tx, logic last);
      reply_beat_t want;
      if (owed_q.size() == 0) begin
        report("reply beat with none owed", tx, 8'h00);
        return;
      end
      want = owed_q.pop_front();
      if (tx !== want.data) report("tx_byte", tx, want.data);
      if (last !== want.last) report("last_byte", 8'(last), 8'(want.last));
    endtask

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic [7:0] live_data_low;
  logic [7:0] live_data_high;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] tx_byte;
  logic       last_byte;

  kline_reply_scoreboard sb = new();

  int cycle_count;
  int rx_items;
  int tx_calm;
  int rx_calm;
  bit holdoff_req;

  kline_frame_responder u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .live_data_low (live_data_low),
    .live_data_high(live_data_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_byte       (tx_byte),
    .last_byte     (last_byte)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // reply beats are checked at the edge that accepts them
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_tx(tx_byte, last_byte);
  end

  // receiver: random stall before each beat, calm stretches, one long hold-off
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    rx_calm   = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 0;
      end
      if (rx_calm > 0) begin
        wait_cycles = 0;
        rx_calm--;
      end else begin
        if ($urandom_range(0, 24) == 0) rx_calm = $urandom_range(10, 50);
        wait_cycles = $urandom_range(0, 8);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  function automatic logic [7:0] pick_live();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // offer one request beat and wait until it is taken
  task automatic send_beat(input logic [7:0] rx, input logic [7:0] lo, input logic [7:0] hi);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      if ($urandom_range(0, 24) == 0) tx_calm = $urandom_range(10, 50);
      gap = $urandom_range(0, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    rx_byte        <= rx;
    live_data_low  <= lo;
    live_data_high <= hi;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_rx(rx, lo, hi);
    rx_items++;
  endtask

  // one request frame; lo and hi ride on the checksum beat
  task automatic send_frame(input logic [5:0] len_code, input logic [7:0] id, input bit set_id,
                            input bit corrupt, input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] fb [0:66];
    logic [7:0] sum;
    int total;
    total = int'(len_code) + MIN_FRAME_LEN;
    fb[0] = FMT_BIT | 8'(len_code);
    for (int i = 1; i < total - 1; i++) fb[i] = 8'($urandom);
    if (set_id && total >= 6) fb[4] = id;
    sum = '0;
    for (int i = 0; i < total - 1; i++) sum = sum + fb[i];
    fb[total - 1] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < total - 1; i++) send_beat(fb[i], pick_live(), pick_live());
    send_beat(fb[total - 1], lo, hi);
  endtask

  // sender goes quiet until every owed reply beat is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pick;
    int r;
    logic [5:0] len_code;
    logic [7:0] id;
    bit holdoff_done;
    bit pause_done;
    bit big_done;

    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = '0;
    live_data_low  = '0;
    live_data_high = '0;
    rx_items       = 0;
    tx_calm        = 0;
    holdoff_req    = 0;
    holdoff_done   = 0;
    pause_done     = 0;
    big_done       = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ignored before sync, even with the top bit set
    send_beat(8'hFF, 8'hFF, 8'hFF);
    send_beat(8'h00, 8'h00, 8'h00);
    // sync byte is also the header of a five-byte frame; first good one gets the start reply
    send_frame(6'd1, 8'h00, 0, 0, 8'h00, 8'hFF);
    // non-header byte between frames
    send_beat(8'h7F, 8'hA5, 8'h5A);
    // long ramp, base wraps past 0xff
    send_frame(6'd2, LONG_ID, 1, 0, 8'hFF, 8'hF0);
    // short ramp
    send_frame(6'd2, SHORT_ID, 1, 0, 8'h00, 8'h00);
    // four-byte frame: checksum captured as service, local id stays zero
    send_frame(6'd0, 8'h00, 0, 0, 8'hFF, 8'hFF);
    // bad checksum, no reply
    send_frame(6'd0, 8'h00, 0, 1, 8'h12, 8'h34);

    while (rx_items < RANDOM_ITEMS) begin
      if (!holdoff_done && rx_items >= 60) begin
        // receiver holds off while frames keep coming, so the job queue fills
        holdoff_req  = 1;
        holdoff_done = 1;
      end
      if (!pause_done && rx_items >= 140) begin
        wait_drained();
        pause_done = 1;
      end
      pick = $urandom_range(0, 99);
      if (!big_done && rx_items >= 100) begin
        // widest frame: bytes past position 4 are summed but not kept
        send_frame(6'h3F, LONG_ID, 1, 0, pick_live(), pick_live());
        big_done = 1;
      end else if (pick < 72) begin
        r = $urandom_range(0, 9);
        if (r < 2) len_code = 6'd0;
        else if (r < 8) len_code = 6'd2;
        else len_code = 6'($urandom_range(3, 5));
        r = $urandom_range(0, 2);
        id = (r == 0) ? LONG_ID : (r == 1) ? SHORT_ID : 8'($urandom);
        send_frame(len_code, id, 1, 0, pick_live(), pick_live());
      end else if (pick < 86) begin
        send_frame(6'($urandom_range(0, 4)), 8'($urandom), 1, 1, pick_live(), pick_live());
      end else if (pick < 95) begin
        send_beat({1'b0, 7'($urandom)}, pick_live(), pick_live());
      end else begin
        // stray header, the frames after it fall out of step
        send_beat(FMT_BIT | 8'($urandom_range(0, 3)), pick_live(), pick_live());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/kfr_pkg.sv
rtl/kfr_front.sv
rtl/kfr_queue.sv
rtl/kfr_back.sv
rtl/kline_frame_responder.sv
tb/kline_frame_responder_test.sv
